// ===== design/pdc_pkg.sv =====
package pdc_pkg;

  // Default width of the capture counter.
  localparam int COUNT_BITS_DEF = 16;

  // Capture channels. The channel field is fixed at two bits, so all four
  // channel numbers are real channels.
  localparam int CHANNELS  = 4;
  localparam int CHAN_BITS = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELOAD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE = 2'd1;

  // Depth of the job queue between the event front end and the math stage.
  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== design/pdc_front.sv =====
module pdc_front #(
  parameter int COUNT_BITS = pdc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [pdc_pkg::CHAN_BITS-1:0]      channel,
  input  logic                               pin_level,
  input  logic [COUNT_BITS-1:0]              capture_count,
  input  logic [pdc_pkg::CHANNELS-1:0]       channel_enable,
  output logic                               push,
  output logic [pdc_pkg::CHAN_BITS+3*COUNT_BITS-1:0] job
);

  localparam logic [1:0] PH_WAIT_RISE = 2'd0;
  localparam logic [1:0] PH_WAIT_FALL = 2'd1;
  localparam logic [1:0] PH_WAIT_NEXT = 2'd2;

  logic [1:0]            phase      [pdc_pkg::CHANNELS];
  logic [COUNT_BITS-1:0] rise_count [pdc_pkg::CHANNELS];
  logic [COUNT_BITS-1:0] fall_count [pdc_pkg::CHANNELS];

  logic [1:0] phase_cur;
  logic       live;
  logic       take_rise;
  logic       take_fall;
  logic       finish;

  assign phase_cur = phase[channel];
  assign live      = accept && channel_enable[channel];

  always_comb begin
    take_rise = 1'b0;
    take_fall = 1'b0;
    finish    = 1'b0;
    unique case (phase_cur)
      PH_WAIT_RISE: take_rise = live && pin_level;
      PH_WAIT_FALL: take_fall = live && !pin_level;
      default:      finish    = live && pin_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < pdc_pkg::CHANNELS; c++) begin
        phase[c] <= PH_WAIT_RISE;
      end
    end else if (take_rise) begin
      phase[channel] <= PH_WAIT_FALL;
    end else if (take_fall) begin
      phase[channel] <= PH_WAIT_NEXT;
    end else if (finish) begin
      phase[channel] <= PH_WAIT_RISE;
    end
  end

  always_ff @(posedge clk) begin
    if (take_rise) begin
      rise_count[channel] <= capture_count;
    end
    if (take_fall) begin
      fall_count[channel] <= capture_count;
    end
  end

  // The completing edge carries its own count plus the two stored counts.
  assign push = finish;
  assign job  = {channel, capture_count, rise_count[channel], fall_count[channel]};

endmodule

// ===== design/pdc_queue.sv =====
module pdc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pdc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("push without pop did not grow the queue");

endmodule

// ===== design/pdc_back.sv =====
module pdc_back #(
  parameter int COUNT_BITS = pdc_pkg::COUNT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       job_valid,
  input  logic [pdc_pkg::CHAN_BITS+3*COUNT_BITS-1:0] job,
  output logic                                       job_pop,
  input  logic [COUNT_BITS-1:0]                      reload_value,
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output logic [pdc_pkg::CHAN_BITS-1:0]              result_channel,
  output logic [COUNT_BITS:0]                        period_ticks,
  output logic [COUNT_BITS-1:0]                      high_ticks
);

  logic [pdc_pkg::CHAN_BITS-1:0] job_ch;
  logic [COUNT_BITS-1:0]         now_cnt;
  logic [COUNT_BITS-1:0]         rise_cnt;
  logic [COUNT_BITS-1:0]         fall_cnt;
  logic [COUNT_BITS:0]           wrap;
  logic [COUNT_BITS:0]           now_adj;
  logic [COUNT_BITS-1:0]         fall_adj;
  logic [COUNT_BITS:0]           period_next;
  logic [COUNT_BITS-1:0]         high_next;

  assign {job_ch, now_cnt, rise_cnt, fall_cnt} = job;

  // A closing count not past the rise count, or a fall count below it, means the counter wrapped once.
  always_comb begin
    wrap        = {1'b0, reload_value} + 1'b1;
    now_adj     = (now_cnt <= rise_cnt) ? {1'b0, now_cnt} + wrap : {1'b0, now_cnt};
    period_next = now_adj - {1'b0, rise_cnt};
    fall_adj    = (fall_cnt < rise_cnt) ? fall_cnt + wrap[COUNT_BITS-1:0] : fall_cnt;
    high_next   = fall_adj - rise_cnt;
  end

  assign job_pop = job_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      result_channel <= job_ch;
      period_ticks   <= period_next;
      high_ticks     <= high_next;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable({result_channel, period_ticks, high_ticks})))
    else $error("stalled result beat changed");

endmodule

// ===== design/pwm_period_duty_capture.sv =====
// PWM input capture: each accepted event beat names a channel, the pin level
// just after the edge and the counter value latched at that edge. An enabled
// channel stores the count of a rising edge, then the count of the following
// falling edge, and on the next rising edge emits one result beat with the
// rise-to-rise period and the rise-to-fall high time; edges that do not fit
// the current phase, and events on disabled channels, are dropped. When the
// closing count is not past the rise count, or the fall count is below it,
// the counter is taken to have wrapped once and reload_value + 1 is added.
// Results are exact modulo the field widths (period COUNT_BITS+1 bits, high
// time COUNT_BITS bits). The block takes one event beat per clock while
// event_stall is low: the front end updates the per-channel phase and stored
// counts in the cycle the beat is accepted, and a completing edge is handed
// through a two-entry queue to the math stage, which registers the result
// beat in its output register. event_stall rises only when the queue is full,
// which happens only after the result side has stalled. Configuration writes
// are always ready and must be issued only while no events are in flight.
module pwm_period_duty_capture #(
  parameter int COUNT_BITS = pdc_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COUNT_BITS-1:0]                cfg_data,
  // Capture event channel.
  input  logic                                 event_valid,
  output logic                                 event_stall,
  input  logic [pdc_pkg::CHAN_BITS-1:0]        channel,
  input  logic                                 pin_level,
  input  logic [COUNT_BITS-1:0]                capture_count,
  // Measurement result channel.
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [pdc_pkg::CHAN_BITS-1:0]        result_channel,
  output logic [COUNT_BITS:0]                  period_ticks,
  output logic [COUNT_BITS-1:0]                high_ticks
);

  localparam int JOB_BITS = pdc_pkg::CHAN_BITS + 3 * COUNT_BITS;

  logic [COUNT_BITS-1:0]        reload_value;
  logic [pdc_pkg::CHANNELS-1:0] channel_enable;

  logic                event_accept;
  logic                q_push;
  logic [JOB_BITS-1:0] q_push_data;
  logic                q_full;
  logic                q_pop;
  logic                q_not_empty;
  logic [JOB_BITS-1:0] q_pop_data;

  // Configuration registers. Writes are taken in any cycle; an index that
  // names no register is simply dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= '0;
      channel_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdc_pkg::REG_RELOAD: reload_value   <= cfg_data;
        pdc_pkg::REG_ENABLE: channel_enable <= cfg_data[pdc_pkg::CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // The event side stalls on every beat while the queue is full, completing edge or not.
  assign event_stall  = q_full;
  assign event_accept = event_valid && !event_stall;

  pdc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (event_accept),
    .channel       (channel),
    .pin_level     (pin_level),
    .capture_count (capture_count),
    .channel_enable(channel_enable),
    .push          (q_push),
    .job           (q_push_data)
  );

  pdc_queue #(
    .WIDTH(JOB_BITS),
    .DEPTH(pdc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_pop_data)
  );

  pdc_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_not_empty),
    .job           (q_pop_data),
    .job_pop       (q_pop),
    .reload_value  (reload_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_channel(result_channel),
    .period_ticks  (period_ticks),
    .high_ticks    (high_ticks)
  );

endmodule

// ===== test/pdc_measure_checker.sv =====
`timescale 1ns / 1ps

module pdc_measure_checker #(
  parameter int COUNT_BITS = pdc_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]            cfg_data,
  input  logic                             event_valid,
  input  logic                             event_stall,
  input  logic [pdc_pkg::CHAN_BITS-1:0]    channel,
  input  logic                             pin_level,
  input  logic [COUNT_BITS-1:0]            capture_count,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic [pdc_pkg::CHAN_BITS-1:0]    result_channel,
  input  logic [COUNT_BITS:0]              period_ticks,
  input  logic [COUNT_BITS-1:0]            high_ticks,
  output int                               errors,
  output int                               pending,
  output int                               events_seen,
  output int                               results_seen,
  output int                               writes_seen
);
  import pdc_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef enum logic [1:0] {AWAIT_RISE, AWAIT_FALL, AWAIT_NEXT_RISE} pulse_phase_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]  chan;
    logic [COUNT_BITS:0]   period;
    logic [COUNT_BITS-1:0] high;
  } measurement_t;

  logic [COUNT_BITS-1:0] reload;
  logic [CHANNELS-1:0]   enabled;
  pulse_phase_t          phase_of [CHANNELS];
  logic [COUNT_BITS-1:0] rise_at [CHANNELS];
  logic [COUNT_BITS-1:0] fall_at [CHANNELS];
  measurement_t          due_measurements [$];
  measurement_t          fresh;
  measurement_t          want;

  // Advances one channel's pulse tracker; returns 1 when the edge completes a period.
  function automatic bit measure_edge(input logic [CHAN_BITS-1:0] ch, input logic rising,
                                      input logic [COUNT_BITS-1:0] cnt,
                                      output measurement_t m);
    logic [COUNT_BITS+1:0] wrap, stop, fall;
    m = '0;
    if (!enabled[ch])
      return 1'b0;
    case (phase_of[ch])
      AWAIT_RISE: begin
        if (rising) begin
          rise_at[ch] = cnt;
          phase_of[ch] = AWAIT_FALL;
        end
        return 1'b0;
      end
      AWAIT_FALL: begin
        if (!rising) begin
          fall_at[ch] = cnt;
          phase_of[ch] = AWAIT_NEXT_RISE;
        end
        return 1'b0;
      end
      default: begin
        if (!rising)
          return 1'b0;
        // A closing count not past the rise count, or a fall count below it, means the counter wrapped once.
        wrap = reload + 1'b1;
        stop = cnt;
        if (cnt <= rise_at[ch])
          stop = stop + wrap;
        fall = fall_at[ch];
        if (fall_at[ch] < rise_at[ch])
          fall = fall + wrap;
        stop = stop - rise_at[ch];
        fall = fall - rise_at[ch];
        m.chan = ch;
        m.period = stop[COUNT_BITS:0];
        m.high = fall[COUNT_BITS-1:0];
        phase_of[ch] = AWAIT_RISE;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report(input string msg);
    if (errors < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reload = '0;
      enabled = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        phase_of[c] = AWAIT_RISE;
        rise_at[c] = '0;
        fall_at[c] = '0;
      end
      due_measurements.delete();
      errors = 0;
      events_seen = 0;
      results_seen = 0;
      writes_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        writes_seen++;
        case (cfg_index)
          REG_RELOAD: reload = cfg_data;
          REG_ENABLE: enabled = cfg_data[CHANNELS-1:0];
          default: ;
        endcase
      end
      // Results leave an output register, so a result beat never belongs to
      // the event beat taken at the same edge; compare before predicting.
      if (result_valid && !result_stall) begin
        results_seen++;
        if (due_measurements.size() == 0) begin
          report($sformatf("result beat on channel %0d with nothing expected", result_channel));
        end else begin
          want = due_measurements.pop_front();
          if (result_channel !== want.chan)
            report($sformatf("result_channel %0d, expected %0d", result_channel, want.chan));
          if (period_ticks !== want.period)
            report($sformatf("channel %0d period_ticks %0d, expected %0d",
                             want.chan, period_ticks, want.period));
          if (high_ticks !== want.high)
            report($sformatf("channel %0d high_ticks %0d, expected %0d",
                             want.chan, high_ticks, want.high));
        end
      end
      if (event_valid && !event_stall) begin
        events_seen++;
        if (measure_edge(channel, pin_level, capture_count, fresh))
          due_measurements.push_back(fresh);
      end
    end
    pending <= due_measurements.size();
  end

endmodule

// ===== test/pwm_period_duty_capture_test.sv =====
`timescale 1ns / 1ps

module pwm_period_duty_capture_test;
  import pdc_pkg::*;

  localparam int CB = COUNT_BITS_DEF;

  // Indexes past the register list; writes there must leave the block alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  localparam logic PIN_LOW  = 1'b0;
  localparam logic PIN_HIGH = 1'b1;

  localparam int MAX_GAP       = 10;
  localparam int LONG_HOLD     = 150;
  // Margin that covers edges that are still inside the front end when the
  // last result shows up.
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 150;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CB-1:0]           cfg_data;
  logic                    event_valid;
  logic                    event_stall;
  logic [CHAN_BITS-1:0]    channel;
  logic                    pin_level;
  logic [CB-1:0]           capture_count;
  logic                    result_valid;
  logic                    result_stall;
  logic [CHAN_BITS-1:0]    result_channel;
  logic [CB:0]             period_ticks;
  logic [CB-1:0]           high_ticks;

  int errors;
  int pending;
  int events_seen;
  int results_seen;
  int writes_seen;

  // Burst modes: when set, that side runs with no idle cycles at all.
  bit tx_steady      = 1'b0;
  bit rx_steady      = 1'b0;
  // Raised by the stimulus to make the result side hold off for a long stretch.
  bit hold_requested = 1'b0;

  // Stimulus-side picture of the counter and of each channel's pin, used to
  // produce realistic PWM edge trains. This is not a prediction.
  int   reload_now;
  logic wave_level [CHANNELS];
  int   wave_pos [CHANNELS];
  int   idle_cycles;

  pwm_period_duty_capture DUT (.*);

  pdc_measure_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One configuration beat. cfg_valid is left high so that back-to-back
  // writes do not drop and re-raise it within one time step; the caller
  // lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Loads both registers, sometimes followed by a write to an unused index.
  task automatic configure(input int reload, input logic [CHANNELS-1:0] mask);
    write_reg(REG_RELOAD, reload[CB-1:0]);
    write_reg(REG_ENABLE, {{(CB-CHANNELS){1'b0}}, mask});
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                CB'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    reload_now = reload;
  endtask

  // One event beat, after a random idle gap unless the sender is in a burst.
  // Returns at the edge where the beat was taken, with event_valid still high.
  task automatic send_event(input logic [CHAN_BITS-1:0] ch, input logic lvl,
                            input logic [CB-1:0] cnt);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_valid   <= 1'b1;
    channel       <= ch;
    pin_level     <= lvl;
    capture_count <= cnt;
    @(posedge clk);
    while (event_stall) @(posedge clk);
  endtask

  // Stops offering events and waits for every pending measurement, then lets
  // edges that produce no result clear the pipeline. The checker's count is
  // registered, so the first look waits for the edge after the last beat.
  task automatic drain();
    event_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A random phase: mostly clean PWM edge trains per channel, with the counter
  // advancing by random spans modulo reload+1 and now and then exactly one full
  // turn, mixed with noise beats that carry any channel, level and count.
  task automatic run_phase(input int n);
    int ch;
    int span;
    int step;
    tx_steady = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) begin
        send_event(CHAN_BITS'($urandom_range(0, CHANNELS - 1)), 1'($urandom_range(0, 1)),
                   CB'($urandom_range(0, 65535)));
      end else begin
        ch = $urandom_range(0, CHANNELS - 1);
        span = reload_now + 1;
        step = ($urandom_range(0, 19) == 0) ? span : $urandom_range(1, span);
        wave_pos[ch] = (wave_pos[ch] + step) % span;
        wave_level[ch] = !wave_level[ch];
        send_event(ch[CHAN_BITS-1:0], wave_level[ch], wave_pos[ch][CB-1:0]);
      end
      if ($urandom_range(0, 49) == 0)
        tx_steady = !tx_steady;
    end
  endtask

  // Result side: draws a stall length for every beat it takes. A pending
  // long hold-off replaces the draw once, so the block's queue fills and the
  // event side gets stalled while the sender keeps offering beats.
  initial begin : result_sink
    int hold;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requested) begin
        hold = LONG_HOLD;
        hold_requested = 1'b0;
      end else begin
        hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      if ($urandom_range(0, 39) == 0)
        rx_steady = !rx_steady;
    end
  end

  // Watchdog: the run is declared hung when no beat moves on any channel
  // long enough for idle_cycles to reach IDLE_LIMIT. The longest legal quiet
  // stretch is the long hold-off, well below the limit.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (event_valid && !event_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int reload;
    logic [CHANNELS-1:0] mask;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    event_valid   <= 1'b0;
    channel       <= '0;
    pin_level     <= PIN_LOW;
    capture_count <= '0;
    reload_now = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      wave_level[c] = PIN_LOW;
      wave_pos[c] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // After reset every channel is disabled, so this rising edge is dropped.
    send_event(2'd0, PIN_HIGH, 16'd100);
    drain();

    // Unused indexes first, written with all ones, then full-scale reload
    // with every channel on.
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    configure(65535, 4'hF);

    // Channel 0: edges that do not fit the phase are skipped at each step
    // (fall while waiting for a rise, a second rise, a second fall).
    send_event(2'd0, PIN_LOW,  16'd50);
    send_event(2'd0, PIN_HIGH, 16'd100);
    send_event(2'd0, PIN_HIGH, 16'd120);
    send_event(2'd0, PIN_LOW,  16'd300);
    send_event(2'd0, PIN_LOW,  16'd310);
    send_event(2'd0, PIN_HIGH, 16'd1100);
    // Channel 1: the closing rise repeats the first count, which reads as
    // one full counter turn, the largest period.
    send_event(2'd1, PIN_HIGH, 16'd5000);
    send_event(2'd1, PIN_LOW,  16'd6000);
    send_event(2'd1, PIN_HIGH, 16'd5000);
    // Channel 2: rise at the top of the counter, fall and next rise after
    // the wrap.
    send_event(2'd2, PIN_HIGH, 16'hFFFF);
    send_event(2'd2, PIN_LOW,  16'h0000);
    send_event(2'd2, PIN_HIGH, 16'h0000);
    // Channel 3: the widest high time.
    send_event(2'd3, PIN_HIGH, 16'h0000);
    send_event(2'd3, PIN_LOW,  16'hFFFF);
    send_event(2'd3, PIN_HIGH, 16'h0000);
    // Channel 0 again: fall on the rise count gives zero high time.
    send_event(2'd0, PIN_HIGH, 16'd7);
    send_event(2'd0, PIN_LOW,  16'd7);
    send_event(2'd0, PIN_HIGH, 16'd8);
    drain();

    // Reload of zero with counts far above it: the wrap correction is a
    // single tick and both results wrap modulo their field widths.
    configure(0, 4'hF);
    send_event(2'd1, PIN_HIGH, 16'd40000);
    send_event(2'd1, PIN_LOW,  16'd10);
    send_event(2'd1, PIN_HIGH, 16'd30);
    // A closing rise one tick below the rise count lands on a zero period.
    send_event(2'd2, PIN_HIGH, 16'd1);
    send_event(2'd2, PIN_LOW,  16'd5);
    send_event(2'd2, PIN_HIGH, 16'd0);
    drain();

    // Random phases, each opened while the block is idle with a new setting.
    // The first one also asks for the long hold-off on the result side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          reload = 65535;
          mask = 4'hF;
        end
        1: begin
          reload = 0;
          mask = 4'hF;
        end
        2: begin
          reload = 65535;
          mask = 4'h0;
        end
        default: begin
          reload = $urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom_range(0, 65535);
          mask = CHANNELS'($urandom_range(1, 15));
        end
      endcase
      configure(reload, mask);
      if (p == 0)
        hold_requested = 1'b1;
      run_phase((p == 2) ? PHASE_ITEMS / 2 : PHASE_ITEMS);
      drain();
    end

    $display("Run covered %0d capture events, %0d checked measurements and %0d register writes,",
             events_seen, results_seen, writes_seen);
    $display("over reload values from zero to full scale, masked channels and back-pressure.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
